// ===== rtl/dwf_pkg.sv =====
// Shared widths and default sizes for the distinct window finder.
package dwf_pkg;

    // Width of the value field carried by the input channel.
    localparam int VALUE_W = 8;

    // Width of the window index fields carried by the output channel.
    localparam int IDX_OUT_W = 12;

    // Default key width; the key span (and so the ring depth) is 2**KEY_BITS.
    localparam int KEY_BITS_DEF = 8;

    // Default number of items whose indices are exact before they saturate.
    localparam int MAX_LEN_DEF = 4096;

endpackage

// ===== rtl/dwf_in_if.sv =====
// Input channel of the distinct window finder: one sequence element per transaction.
interface dwf_in_if;
    import dwf_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);

endinterface

// ===== rtl/dwf_out_if.sv =====
// Output channel of the distinct window finder: one reported window per transaction.
interface dwf_out_if;
    import dwf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [IDX_OUT_W-1:0] win_start;
    logic [IDX_OUT_W-1:0] win_end;
    logic                 seq_done;
    logic                 overrun;

    modport source (output valid, output win_start, output win_end, output seq_done,
                    output overrun, input ready);
    modport sink   (input valid, input win_start, input win_end, input seq_done,
                    input overrun, output ready);

endinterface

// ===== rtl/dwf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module dwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/distinct_window_finder.sv =====
// Top level of the distinct window finder: window tracking sequencer and result register.
//
// The block watches a stream of keys, one per input transaction, with last_item marking
// the end of a sequence, and reports every maximal run of consecutive items whose keys
// are all different as a pair of item indices (win_start, win_end inclusive). When an
// arriving key is already inside the current window, the window that just ended is
// reported with seq_done low, and the start is walked forward one element per cycle,
// each step reading the oldest key out of the ring memory, clearing its seen bit unless
// it matches the new key, until the copy of the new key has left the window.
// The seen bits live in a one-bit RAM indexed by key; the lookup is issued while the
// item is accepted, so the data is ready for the check in the next cycle. On the last
// item the closing window is reported with seq_done high, the indices are cleared, and
// the elements still in the window are walked out of the ring to clear their seen bits.
// After reset the seen RAM is cleared by a pass over all 2**KEY_BITS keys (256 by default)
// during which input ready stays low. Indices saturate at MAX_LEN-1; once any item of a
// sequence had an index of MAX_LEN or more, overrun is high on every later window of
// that sequence.
// An item whose key is new is accepted with the seen lookup, then checked and appended.
// For an item that repeats a key, elements are then removed from the window one by one,
// as the single read port of the ring memory yields one element per cycle to the shared
// compare. The last item of a sequence adds the closing window and then the walk over
// the elements left in the window, between 1 and 2**KEY_BITS of them. Every element
// enters and leaves the window once.
// Input ready is high only while the sequencer is idle. Results sit in an output
// register, so the sequencer only stalls when it must report a window while the
// previous one has not yet been taken.
module distinct_window_finder #(
    parameter int KEY_BITS = dwf_pkg::KEY_BITS_DEF,
    parameter int MAX_LEN  = dwf_pkg::MAX_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dwf_in_if.sink    i_item,
    dwf_out_if.source o_win
);
    import dwf_pkg::*;

    localparam int KEY_SPAN = 1 << KEY_BITS;
    localparam int IDX_W    = $clog2(MAX_LEN + 1);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_SAT = IDX_W'(MAX_LEN);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_POP,
        S_LAST,
        S_FLUSH
    } t_state;

    t_state r_state;

    // Address of the seen RAM clearing pass after reset.
    logic [KEY_BITS-1:0] r_clr_addr;

    // Current transaction.
    logic [KEY_BITS-1:0] r_key;
    logic                r_last;
    logic [IDX_W-1:0]    r_idx;

    // Window state.
    logic [KEY_BITS-1:0] r_head;
    logic [KEY_BITS:0]   r_len;
    logic [IDX_W-1:0]    r_start;
    logic [IDX_W-1:0]    r_next;
    logic                r_ovr;

    // Result register.
    logic                 r_out_valid;
    logic [IDX_OUT_W-1:0] r_out_start;
    logic [IDX_OUT_W-1:0] r_out_end;
    logic                 r_out_done;
    logic                 r_out_ovr;

    logic [KEY_BITS-1:0] key_in;
    logic                out_free;
    logic                out_load;
    logic                dup;
    logic                pop_hit;
    logic [IDX_W-1:0]    n_start;
    logic [IDX_W-1:0]    n_next;
    logic [IDX_W-1:0]    dup_end;
    logic [IDX_W-1:0]    last_end;

    logic                ram_we;
    logic [KEY_BITS-1:0] ram_waddr;
    logic [KEY_BITS-1:0] ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    logic                seen_we;
    logic [KEY_BITS-1:0] seen_waddr;
    logic                seen_wdata;
    logic [KEY_BITS-1:0] seen_raddr;
    logic                seen_rdata;

    assign key_in   = KEY_BITS'(i_item.value);
    assign out_free = !r_out_valid || o_win.ready;
    assign dup      = seen_rdata;
    assign out_load = out_free && (((r_state == S_CHECK) && dup) || (r_state == S_LAST));

    // The one compare of the start walk: has the oldest element reached the new key?
    assign pop_hit  = (ram_rdata == r_key);

    assign n_start  = (r_start < IDX_MAX) ? r_start + 1'b1 : r_start;
    assign n_next   = (r_next != IDX_SAT) ? r_next + 1'b1 : r_next;
    assign dup_end  = (r_idx > r_start) ? r_idx - 1'b1 : r_start;
    assign last_end = (r_idx >= r_start) ? r_idx : r_start;

    // The new key is appended behind the window. When the walk ends in the same cycle,
    // the head moves up by one and one element leaves, so this address still holds.
    assign ram_we    = ((r_state == S_CHECK) && !dup) || ((r_state == S_POP) && pop_hit);
    assign ram_waddr = r_head + r_len[KEY_BITS-1:0];

    // During a walk the next element is fetched one ahead so that one pops per cycle.
    assign ram_raddr = ((r_state == S_POP) || (r_state == S_FLUSH)) ? r_head + 1'b1 : r_head;

    // The seen bit of the arriving key is looked up while it is accepted and held
    // on the same address while the check waits for the result register.
    assign seen_raddr = (r_state == S_IDLE) ? key_in : r_key;
    assign seen_we    = (r_state == S_INIT) || ((r_state == S_CHECK) && !dup) ||
                        ((r_state == S_POP) && !pop_hit) || (r_state == S_FLUSH);
    assign seen_waddr = (r_state == S_INIT)  ? r_clr_addr :
                        (r_state == S_CHECK) ? r_key : ram_rdata;
    assign seen_wdata = (r_state == S_CHECK);

    dwf_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (KEY_SPAN),
        .AW    (KEY_BITS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_key),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dwf_ram #(
        .WIDTH (1),
        .DEPTH (KEY_SPAN),
        .AW    (KEY_BITS)
    ) u_seen (
        .i_clk   (i_clk),
        .i_we    (seen_we),
        .i_waddr (seen_waddr),
        .i_wdata (seen_wdata),
        .i_raddr (seen_raddr),
        .o_rdata (seen_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_len       <= '0;
            r_start     <= '0;
            r_next      <= '0;
            r_ovr       <= 1'b0;
        end else begin
            if (o_win.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_INIT: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (i_item.valid) begin
                        r_key  <= key_in;
                        r_last <= i_item.last_item;
                        if (r_next == IDX_SAT) begin
                            r_idx <= IDX_MAX;
                            r_ovr <= 1'b1;
                        end else begin
                            r_idx <= r_next;
                        end
                        r_state <= S_CHECK;
                    end
                end

                S_CHECK: begin
                    if (!dup) begin
                        r_len   <= r_len + 1'b1;
                        r_next  <= n_next;
                        r_state <= r_last ? S_LAST : S_IDLE;
                    end else if (out_free) begin
                        // Report the window that the repeated key just ended.
                        r_out_valid <= 1'b1;
                        r_out_start <= IDX_OUT_W'(r_start);
                        r_out_end   <= IDX_OUT_W'(dup_end);
                        r_out_done  <= 1'b0;
                        r_out_ovr   <= r_ovr;
                        r_state     <= S_POP;
                    end
                end

                S_POP: begin
                    r_head  <= r_head + 1'b1;
                    r_start <= n_start;
                    if (pop_hit) begin
                        // The old copy leaves and the new one enters: the seen bit stays
                        // set and the length is unchanged.
                        r_next  <= n_next;
                        r_state <= r_last ? S_LAST : S_IDLE;
                    end else begin
                        r_len <= r_len - 1'b1;
                    end
                end

                S_LAST: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_start <= IDX_OUT_W'(r_start);
                        r_out_end   <= IDX_OUT_W'(last_end);
                        r_out_done  <= 1'b1;
                        r_out_ovr   <= r_ovr;
                        r_start     <= '0;
                        r_next      <= '0;
                        r_ovr       <= 1'b0;
                        r_state     <= S_FLUSH;
                    end
                end

                S_FLUSH: begin
                    // Each remaining element leaves the ring and its seen bit is cleared.
                    r_head <= r_head + 1'b1;
                    r_len  <= r_len - 1'b1;
                    if (r_len == {{KEY_BITS{1'b0}}, 1'b1}) begin
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready    = (r_state == S_IDLE);
    assign o_win.valid     = r_out_valid;
    assign o_win.win_start = r_out_start;
    assign o_win.win_end   = r_out_end;
    assign o_win.seq_done  = r_out_done;
    assign o_win.overrun   = r_out_ovr;

    // A window waiting in the result register stays put until it is taken.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_win.ready) |=> (r_out_valid && $stable(r_out_start) &&
            $stable(r_out_end) && $stable(r_out_done) && $stable(r_out_ovr)))
        else $error("waiting window changed before it was taken");

    // Before any index saturates and outside the flush walk, the window start plus its length is the item count.
    a_window_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next != IDX_SAT && r_state != S_FLUSH) |->
            (int'(r_start) + int'(r_len) == int'(r_next)))
        else $error("window start and length disagree with item count");

    // Reporting the closing window clears the indices and starts the flush walk.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST && out_free) |=>
            (r_state == S_FLUSH && r_start == '0 && r_next == '0 && !r_ovr))
        else $error("state not cleared after the closing window");

    // The ring never holds more keys than the key span allows.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_len) <= KEY_SPAN)
        else $error("window length exceeds key span");

endmodule

// ===== verif/dwf_window_checker.sv =====
// Checker for the distinct window finder: predicts the reported windows and compares them.
module dwf_window_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_closing,
    dwf_in_if    item_mon,
    dwf_out_if   win_mon,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dwf_pkg::*;

    localparam int KEY_SPAN = 1 << KEY_BITS_DEF;
    localparam int IDX_LAST = MAX_LEN_DEF - 1;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] win_start;
        logic [IDX_OUT_W-1:0] win_end;
        logic                 seq_done;
        logic                 overrun;
    } window_t;

    window_t                 expected_windows[$];
    bit                      seen_key[KEY_SPAN];
    logic [KEY_BITS_DEF-1:0] key_ring[KEY_SPAN];
    int unsigned             win_first;
    int unsigned             items_taken;
    int unsigned             ring_head;
    int unsigned             ring_len;
    bit                      overrun_seen;
    int                      fails = 0;
    bit                      leftovers_checked = 1'b0;

    function automatic void clear_sequence();
        foreach (seen_key[k]) seen_key[k] = 1'b0;
        win_first    = 0;
        items_taken  = 0;
        ring_head    = 0;
        ring_len     = 0;
        overrun_seen = 1'b0;
    endfunction

    function automatic void push_window(int unsigned lo, int unsigned hi, bit done);
        window_t w;
        w.win_start = lo[IDX_OUT_W-1:0];
        w.win_end   = hi[IDX_OUT_W-1:0];
        w.seq_done  = done;
        w.overrun   = overrun_seen;
        expected_windows.push_back(w);
    endfunction

    // Index saturation keeps item positions at IDX_LAST once a sequence runs long;
    // the ring itself keeps working so the window contents stay exact.
    function automatic void predict_windows(logic [VALUE_W-1:0] value, logic last);
        int unsigned key;
        int unsigned pos;
        int unsigned gone;
        key = value & (KEY_SPAN - 1);
        if (items_taken > IDX_LAST) begin
            overrun_seen = 1'b1;
            pos = IDX_LAST;
        end else begin
            pos = items_taken;
        end
        if (seen_key[key]) begin
            push_window(win_first, (pos > win_first) ? pos - 1 : win_first, 1'b0);
            while (seen_key[key] && ring_len > 0) begin
                gone = key_ring[ring_head];
                seen_key[gone] = 1'b0;
                ring_head = (ring_head + 1) % KEY_SPAN;
                ring_len--;
                if (win_first < IDX_LAST) win_first++;
            end
            seen_key[key] = 1'b0;
        end
        if (ring_len < KEY_SPAN) begin
            key_ring[(ring_head + ring_len) % KEY_SPAN] = key[KEY_BITS_DEF-1:0];
            ring_len++;
        end
        seen_key[key] = 1'b1;
        if (items_taken <= IDX_LAST) items_taken++;
        if (last) begin
            push_window(win_first, (pos >= win_first) ? pos : win_first, 1'b1);
            clear_sequence();
        end
    endfunction

    function automatic void compare_window(window_t got);
        window_t want;
        if (expected_windows.size() == 0) begin
            $error("window (%0d, %0d) reported with none expected", got.win_start, got.win_end);
            fails++;
            return;
        end
        want = expected_windows.pop_front();
        if (got.win_start !== want.win_start) begin
            $error("win_start: expected %0d, got %0d", want.win_start, got.win_start);
            fails++;
        end
        if (got.win_end !== want.win_end) begin
            $error("win_end: expected %0d, got %0d", want.win_end, got.win_end);
            fails++;
        end
        if (got.seq_done !== want.seq_done) begin
            $error("seq_done: expected %0b, got %0b", want.seq_done, got.seq_done);
            fails++;
        end
        if (got.overrun !== want.overrun) begin
            $error("overrun: expected %0b, got %0b", want.overrun, got.overrun);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        window_t got;
        if (!i_rst_n) begin
            clear_sequence();
            expected_windows.delete();
        end else begin
            if (item_mon.valid && item_mon.ready)
                predict_windows(item_mon.value, item_mon.last_item);
            if (win_mon.valid && win_mon.ready) begin
                got.win_start = win_mon.win_start;
                got.win_end   = win_mon.win_end;
                got.seq_done  = win_mon.seq_done;
                got.overrun   = win_mon.overrun;
                compare_window(got);
            end
            if (i_closing && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (expected_windows.size() != 0) begin
                    $error("%0d expected windows never reported", expected_windows.size());
                    fails += expected_windows.size();
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_windows.size();
    end

endmodule

// ===== verif/tb_distinct_window_finder.sv =====
// Testbench top for the distinct window finder: clock, reset, stimulus and verdict.
module tb_distinct_window_finder;
    timeunit 1ns;
    timeprecision 1ps;
    import dwf_pkg::*;

    // Longest idle burst on either channel, in cycles.
    localparam int MAX_GAP = 18;
    // Length of the one long output stall that backs the block up to its input.
    localparam int HOLD_CYCLES = 150;
    // Item count at which the random short sequences stop.
    localparam int RANDOM_ITEMS = 100;
    // Items in the closing phase, which runs with no idling at all.
    localparam int CLOSING_ITEMS = 40;

    logic i_clk;
    logic i_rst_n;

    dwf_in_if  item_if ();
    dwf_out_if win_if ();

    bit sender_idle_en;
    bit receiver_idle_en;
    int hold_requests = 0;
    int holds_served = 0;
    int items_sent = 0;
    bit closing;
    int fail_count;
    int pending;

    distinct_window_finder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_win   (win_if)
    );

    // The checker sees every transaction on both channels; it owns all prediction
    // and comparison and only hands back its failure and backlog counts.
    dwf_window_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_closing    (closing),
        .item_mon     (item_if),
        .win_mon      (win_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Nothing here should take more than a few percent of this; it only catches hangs.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result receiver. It changes ready only on falling edges. Normally it alternates
    // short stall bursts with stretches of steady readiness; on request from the
    // stimulus it holds off for one long stretch so the block's pipeline fills and
    // input ready drops while items are still being offered.
    initial begin
        win_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                win_if.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (receiver_idle_en && $urandom_range(0, 7) == 0) begin
                win_if.ready = 1'b0;
                repeat ($urandom_range(1, MAX_GAP) - 1) @(negedge i_clk);
            end else begin
                win_if.ready = 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge i_clk);
            end
        end
    end

    // Offers one sequence element and returns on the falling edge after the block
    // took the transaction. Valid is left high so back-to-back items need no gap;
    // an idle burst, when drawn, comes before the item.
    task automatic offer_item(input logic [VALUE_W-1:0] value, input logic last);
        if (sender_idle_en && $urandom_range(0, 4) == 0) begin
            item_if.valid = 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(negedge i_clk);
        end
        item_if.valid     = 1'b1;
        item_if.value     = value;
        item_if.last_item = last;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        @(negedge i_clk);
        items_sent++;
    endtask

    // A sequence whose keys come from a window of span+1 values at a random base.
    // Small spans make duplicates, and so reported windows, frequent.
    task automatic run_sequence(input int len, input int span);
        logic [VALUE_W-1:0] base;
        base = VALUE_W'($urandom);
        for (int n = 0; n < len; n++)
            offer_item(base + VALUE_W'($urandom_range(0, span)), n == len - 1);
    endtask

    // Every key once in shuffled order, so the window grows to the full key span,
    // followed by two random keys that are both bound to repeat.
    task automatic send_permutation();
        logic [VALUE_W-1:0] order[1 << VALUE_W];
        logic [VALUE_W-1:0] swap;
        int                 pick;
        foreach (order[k]) order[k] = VALUE_W'(k);
        for (int k = (1 << VALUE_W) - 1; k > 0; k--) begin
            pick        = $urandom_range(0, k);
            swap        = order[k];
            order[k]    = order[pick];
            order[pick] = swap;
        end
        foreach (order[k]) offer_item(order[k], 1'b0);
        offer_item(VALUE_W'($urandom), 1'b0);
        offer_item(VALUE_W'($urandom), 1'b1);
    endtask

    // Stops offering until every predicted window has been taken.
    task automatic wait_drained();
        item_if.valid = 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin
        bit hold_done;
        bit pause_done;
        int target;

        item_if.valid     = 1'b0;
        item_if.value     = '0;
        item_if.last_item = 1'b0;
        sender_idle_en    = 1'b1;
        receiver_idle_en  = 1'b1;
        closing           = 1'b0;
        hold_done         = 1'b0;
        pause_done        = 1'b0;

        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // A sequence of a single item: the closing window is just index 0.
        offer_item(8'h00, 1'b1);
        // The final item repeats the previous key, so one transaction yields two
        // windows: the one ended by the duplicate, then the closing one.
        offer_item(8'hFF, 1'b0);
        offer_item(8'hFF, 1'b1);
        // Extreme and alternating bit patterns; the repeat of 55 walks the start
        // past three elements, the repeat of AA past one.
        offer_item(8'h00, 1'b0);
        offer_item(8'hFF, 1'b0);
        offer_item(8'h55, 1'b0);
        offer_item(8'hAA, 1'b0);
        offer_item(8'h55, 1'b0);
        offer_item(8'h00, 1'b0);
        offer_item(8'hAA, 1'b0);
        offer_item(8'h01, 1'b1);
        // The same key three times in a row; each repeat is a one-element walk.
        offer_item(8'h07, 1'b0);
        offer_item(8'h07, 1'b0);
        offer_item(8'h07, 1'b1);

        // Random short sequences. Along the way the receiver is asked for one long
        // stall while the sender offers a dense burst without gaps, and later the
        // sender pauses until every expected window has arrived.
        while (items_sent < RANDOM_ITEMS) begin
            if (!hold_done && items_sent >= 30) begin
                hold_done = 1'b1;
                item_if.valid = 1'b0;
                hold_requests++;
                wait (holds_served == hold_requests);
                sender_idle_en = 1'b0;
                run_sequence(40, 15);
                sender_idle_en = 1'b1;
            end else if (!pause_done && items_sent >= 80) begin
                pause_done = 1'b1;
                wait_drained();
            end else begin
                run_sequence($urandom_range(1, 24), (1 << $urandom_range(1, 8)) - 1);
            end
        end

        send_permutation();
        wait_drained();

        // Closing phase with no idling on either side.
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        target = items_sent + CLOSING_ITEMS;
        while (items_sent < target)
            run_sequence($urandom_range(1, 24), (1 << $urandom_range(1, 8)) - 1);

        wait_drained();
        // Idle a little longer so any stray window the block might still emit is caught.
        repeat (20) @(negedge i_clk);
        closing = 1'b1;
        repeat (2) @(negedge i_clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
